[design/qcn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion compose and normalise package
// Widths, constants, types and the product sign table shared by the core
// and its checker.
// ----------------------------------------------------------------------------
package qcn_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 30;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int TERM_W    = PROD_W - FRAC_BITS;
   localparam int ACC_W     = TERM_W + 2;
   localparam int MAG_W     = DATA_W - 1;
   localparam int QUO_W     = DATA_W - 1;
   localparam int NUM_W     = MAG_W + FRAC_BITS;
   localparam int CNT_W     = 5;
   localparam int LANES     = 4;

   localparam int MUL_LAST  = 16;
   localparam int SQR_LAST  = 4;
   localparam int ROOT_LAST = 31;
   localparam int DIV_LAST  = QUO_W - 1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic        [PROD_W-1:0] wide_type;
   typedef logic        [MAG_W-1:0]  mag_type;
   typedef logic        [QUO_W-1:0]  quo_type;
   typedef logic        [NUM_W-1:0]  num_type;
   typedef logic        [CNT_W-1:0]  cnt_type;
   typedef logic        [1:0]        lane_type;

   localparam data_type ONE      = data_type'(64'd1 << FRAC_BITS);
   localparam data_type SAT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type SAT_MIN  = -SAT_MAX;
   localparam acc_type  ACC_HI   = acc_type'(SAT_MAX);
   localparam acc_type  ACC_LO   = -ACC_HI;
   localparam prod_type RND_HALF = prod_type'(64'd1 << (FRAC_BITS - 1));
   localparam wide_type BIT_INIT = wide_type'(64'd1 << (PROD_W - 2));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_SQR,
      ST_ROOT,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_FINISH
   } state_type;

   // Partial product idx = {component, term}; true where the Hamilton
   // product subtracts that term.
   function automatic logic term_neg(input logic [3:0] idx);
      logic neg;
      case (idx)
         4'd1, 4'd2, 4'd3, 4'd6, 4'd11, 4'd13: neg = 1'b1;
         default:                             neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage
`default_nettype wire

[design/quaternion_compose_normalize_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion compose and normalise core
// Multiplies the held Q1.30 orientation by each delta quaternion and
// normalises the product by its integer square-root norm.
// ----------------------------------------------------------------------------
// Each request keeps the block busy from acceptance until its result is loaded,
// so a new request is accepted only once the previous one has been finished.
// One 32 by 32 multiplier forms the sixteen partial products and the four
// squares; a square-root loop follows, and a restoring divider runs over each
// of the four components in turn, or skips the division of a component that
// saturates. A degenerate product skips the divisions. The result is held in an
// output register, so a new request is accepted while the previous result waits
// to be taken; the block only waits before loading its next result while the
// previous one has not been taken.
module quaternion_compose_normalize_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [qcn_pkg::DATA_W-1:0]    req_delta_w,
   input  logic signed [qcn_pkg::DATA_W-1:0]    req_delta_x,
   input  logic signed [qcn_pkg::DATA_W-1:0]    req_delta_y,
   input  logic signed [qcn_pkg::DATA_W-1:0]    req_delta_z,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qcn_pkg::DATA_W-1:0]    rsp_out_w,
   output logic signed [qcn_pkg::DATA_W-1:0]    rsp_out_x,
   output logic signed [qcn_pkg::DATA_W-1:0]    rsp_out_y,
   output logic signed [qcn_pkg::DATA_W-1:0]    rsp_out_z,
   output logic                                 rsp_degenerate
);

   qcn_pkg::state_type state_ff, state_in;
   qcn_pkg::cnt_type   cnt_ff, cnt_in;
   qcn_pkg::lane_type  lane_ff, lane_in;
   logic               rsp_valid_ff, rsp_valid_in;

   qcn_pkg::data_type  orient_ff [qcn_pkg::LANES];
   qcn_pkg::data_type  delta_ff  [qcn_pkg::LANES];
   qcn_pkg::acc_type   acc_ff    [qcn_pkg::LANES];
   qcn_pkg::mag_type   mag_ff    [qcn_pkg::LANES];
   logic [qcn_pkg::LANES-1:0] neg_ff;
   qcn_pkg::prod_type  prod_ff;
   logic [3:0]         pidx_ff;
   qcn_pkg::wide_type  sum_ff;
   qcn_pkg::wide_type  rt_ff;
   qcn_pkg::wide_type  bit_ff;
   logic [qcn_pkg::DATA_W-1:0] rem_ff;
   qcn_pkg::quo_type   low_ff;
   qcn_pkg::quo_type   quo_ff;
   logic               degen_ff;
   qcn_pkg::data_type  out_w_ff, out_x_ff, out_y_ff, out_z_ff;
   logic               out_degen_ff;

   logic               accept;
   logic               rsp_load;
   logic               rsp_free;

   qcn_pkg::data_type  mul_a, mul_b;
   qcn_pkg::prod_type  mul_p;
   qcn_pkg::prod_type  prod_rnd, prod_sh;
   qcn_pkg::acc_type   term_ext;

   qcn_pkg::acc_type   sat_val [qcn_pkg::LANES];
   qcn_pkg::acc_type   sat_abs [qcn_pkg::LANES];

   qcn_pkg::wide_type  rt_trial;
   logic               rt_ge;

   logic [qcn_pkg::DATA_W-1:0] root;
   qcn_pkg::num_type   div_num;
   logic               div_ovf;
   logic [qcn_pkg::DATA_W:0]   div_trial, div_diff;
   logic               div_ge;
   qcn_pkg::quo_type   quo_next;
   qcn_pkg::data_type  quo_signed;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      lane_in  = lane_ff;
      case (state_ff)
         qcn_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = qcn_pkg::ST_MUL;
               cnt_in   = '0;
            end
         end
         qcn_pkg::ST_MUL: begin
            if (cnt_ff == qcn_pkg::cnt_type'(qcn_pkg::MUL_LAST)) begin
               state_in = qcn_pkg::ST_SAT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qcn_pkg::ST_SAT: begin
            state_in = qcn_pkg::ST_SQR;
            cnt_in   = '0;
         end
         qcn_pkg::ST_SQR: begin
            if (cnt_ff == qcn_pkg::cnt_type'(qcn_pkg::SQR_LAST)) begin
               state_in = qcn_pkg::ST_ROOT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qcn_pkg::ST_ROOT: begin
            if (cnt_ff == qcn_pkg::cnt_type'(qcn_pkg::ROOT_LAST)) begin
               state_in = qcn_pkg::ST_CHECK;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qcn_pkg::ST_CHECK: begin
            lane_in = '0;
            if (root == '0) begin
               state_in = qcn_pkg::ST_FINISH;
            end else begin
               state_in = qcn_pkg::ST_DIV_LOAD;
            end
         end
         qcn_pkg::ST_DIV_LOAD: begin
            cnt_in = '0;
            if (div_ovf) begin
               lane_in = lane_ff + 1'b1;
               if (lane_ff == 2'd3) begin
                  state_in = qcn_pkg::ST_FINISH;
               end
            end else begin
               state_in = qcn_pkg::ST_DIV_STEP;
            end
         end
         qcn_pkg::ST_DIV_STEP: begin
            if (cnt_ff == qcn_pkg::cnt_type'(qcn_pkg::DIV_LAST)) begin
               lane_in = lane_ff + 1'b1;
               cnt_in  = '0;
               if (lane_ff == 2'd3) begin
                  state_in = qcn_pkg::ST_FINISH;
               end else begin
                  state_in = qcn_pkg::ST_DIV_LOAD;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qcn_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = qcn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qcn_pkg::ST_IDLE;
         end
      endcase
   end

   // Output decode.
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         qcn_pkg::ST_IDLE:   req_ready = 1'b1;
         qcn_pkg::ST_FINISH: rsp_load  = rsp_free;
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (state_ff)
         qcn_pkg::ST_MUL: begin
            mul_a = orient_ff[cnt_ff[3:2] ^ cnt_ff[1:0]];
            mul_b = delta_ff[cnt_ff[1:0]];
         end
         qcn_pkg::ST_SQR: begin
            mul_a = qcn_pkg::data_type'({1'b0, mag_ff[cnt_ff[1:0]]});
            mul_b = qcn_pkg::data_type'({1'b0, mag_ff[cnt_ff[1:0]]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = qcn_pkg::prod_type'(mul_a) * qcn_pkg::prod_type'(mul_b);
   assign prod_rnd = prod_ff + qcn_pkg::RND_HALF;
   assign prod_sh  = prod_rnd >>> qcn_pkg::FRAC_BITS;
   assign term_ext = qcn_pkg::acc_type'(qcn_pkg::term_type'(prod_sh));

   always_comb begin
      for (int i = 0; i < qcn_pkg::LANES; i++) begin
         if (acc_ff[i] > qcn_pkg::ACC_HI) begin
            sat_val[i] = qcn_pkg::ACC_HI;
         end else if (acc_ff[i] < qcn_pkg::ACC_LO) begin
            sat_val[i] = qcn_pkg::ACC_LO;
         end else begin
            sat_val[i] = acc_ff[i];
         end
         sat_abs[i] = acc_ff[i][qcn_pkg::ACC_W-1] ? -sat_val[i] : sat_val[i];
      end
   end

   assign rt_trial = rt_ff + bit_ff;
   assign rt_ge    = sum_ff >= rt_trial;

   assign root       = rt_ff[qcn_pkg::DATA_W-1:0];
   assign div_num    = {mag_ff[lane_ff], {qcn_pkg::FRAC_BITS{1'b0}}};
   assign div_ovf    = qcn_pkg::wide_type'(div_num)
                       >= qcn_pkg::wide_type'({root, {qcn_pkg::QUO_W{1'b0}}});
   assign div_trial  = {rem_ff, low_ff[qcn_pkg::QUO_W-1]};
   assign div_ge     = div_trial >= {1'b0, root};
   assign div_diff   = div_trial - {1'b0, root};
   assign quo_next   = {quo_ff[qcn_pkg::QUO_W-2:0], div_ge};
   assign quo_signed = qcn_pkg::data_type'({1'b0, quo_next});

   // Control state and the held orientation.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qcn_pkg::ST_IDLE;
         cnt_ff       <= '0;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         orient_ff[0] <= qcn_pkg::ONE;
         orient_ff[1] <= '0;
         orient_ff[2] <= '0;
         orient_ff[3] <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && req_restart) begin
            orient_ff[0] <= qcn_pkg::ONE;
            orient_ff[1] <= '0;
            orient_ff[2] <= '0;
            orient_ff[3] <= '0;
         end
         if (state_ff == qcn_pkg::ST_DIV_LOAD && div_ovf) begin
            orient_ff[lane_ff] <= neg_ff[lane_ff] ? qcn_pkg::SAT_MIN : qcn_pkg::SAT_MAX;
         end
         if (state_ff == qcn_pkg::ST_DIV_STEP
             && cnt_ff == qcn_pkg::cnt_type'(qcn_pkg::DIV_LAST)) begin
            orient_ff[lane_ff] <= neg_ff[lane_ff] ? -quo_signed : quo_signed;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      pidx_ff <= cnt_ff[3:0];
      case (state_ff)
         qcn_pkg::ST_IDLE: begin
            if (accept) begin
               delta_ff[0] <= req_delta_w;
               delta_ff[1] <= req_delta_x;
               delta_ff[2] <= req_delta_y;
               delta_ff[3] <= req_delta_z;
               for (int i = 0; i < qcn_pkg::LANES; i++) begin
                  acc_ff[i] <= '0;
               end
               degen_ff <= 1'b0;
            end
         end
         qcn_pkg::ST_MUL: begin
            if (cnt_ff != '0) begin
               if (qcn_pkg::term_neg(pidx_ff)) begin
                  acc_ff[pidx_ff[3:2]] <= acc_ff[pidx_ff[3:2]] - term_ext;
               end else begin
                  acc_ff[pidx_ff[3:2]] <= acc_ff[pidx_ff[3:2]] + term_ext;
               end
            end
         end
         qcn_pkg::ST_SAT: begin
            for (int i = 0; i < qcn_pkg::LANES; i++) begin
               mag_ff[i] <= qcn_pkg::mag_type'(sat_abs[i]);
               neg_ff[i] <= acc_ff[i][qcn_pkg::ACC_W-1];
            end
            sum_ff <= '0;
         end
         qcn_pkg::ST_SQR: begin
            if (cnt_ff != '0) begin
               sum_ff <= sum_ff + qcn_pkg::wide_type'(prod_ff);
            end
            rt_ff  <= '0;
            bit_ff <= qcn_pkg::BIT_INIT;
         end
         qcn_pkg::ST_ROOT: begin
            if (rt_ge) begin
               sum_ff <= sum_ff - rt_trial;
               rt_ff  <= (rt_ff >> 1) + bit_ff;
            end else begin
               rt_ff  <= rt_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         qcn_pkg::ST_CHECK: begin
            degen_ff <= root == '0;
         end
         qcn_pkg::ST_DIV_LOAD: begin
            rem_ff <= qcn_pkg::DATA_W'(div_num >> qcn_pkg::QUO_W);
            low_ff <= div_num[qcn_pkg::QUO_W-1:0];
            quo_ff <= '0;
         end
         qcn_pkg::ST_DIV_STEP: begin
            rem_ff <= div_ge ? div_diff[qcn_pkg::DATA_W-1:0]
                             : div_trial[qcn_pkg::DATA_W-1:0];
            low_ff <= {low_ff[qcn_pkg::QUO_W-2:0], 1'b0};
            quo_ff <= quo_next;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         out_w_ff     <= orient_ff[0];
         out_x_ff     <= orient_ff[1];
         out_y_ff     <= orient_ff[2];
         out_z_ff     <= orient_ff[3];
         out_degen_ff <= degen_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_w      = out_w_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_out_z      = out_z_ff;
   assign rsp_degenerate = out_degen_ff;

endmodule
`default_nettype wire

[design/qcn_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion compose and normalise checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module qcn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [qcn_pkg::DATA_W-1:0]  req_delta_w,
   input logic signed [qcn_pkg::DATA_W-1:0]  req_delta_x,
   input logic signed [qcn_pkg::DATA_W-1:0]  req_delta_y,
   input logic signed [qcn_pkg::DATA_W-1:0]  req_delta_z,
   input logic                               req_restart,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [qcn_pkg::DATA_W-1:0]  rsp_out_w,
   input logic signed [qcn_pkg::DATA_W-1:0]  rsp_out_x,
   input logic signed [qcn_pkg::DATA_W-1:0]  rsp_out_y,
   input logic signed [qcn_pkg::DATA_W-1:0]  rsp_out_z,
   input logic                               rsp_degenerate
);

   localparam logic [qcn_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {(qcn_pkg::DATA_W-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A stalled response was withdrawn.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_w) && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_degenerate))
      else $error("A stalled response changed.");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("The core was ready again straight after accepting a request.");

   a_symmetric_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_w != MOST_NEG && rsp_out_x != MOST_NEG
         && rsp_out_y != MOST_NEG && rsp_out_z != MOST_NEG)
      else $error("A response component lies outside the symmetric range.");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("The core did not come out of reset idle.");

endmodule

bind quaternion_compose_normalize_core qcn_checker u_qcn_checker (.*);
`default_nettype wire

[verif/tb_quaternion_compose_normalize_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the quaternion compose and normalise core
// Sends delta quaternions through the request channel, works out each new
// orientation with an independent fixed-point model of the Hamilton product
// and its normalisation, and compares every response field by field. A table
// of directed corner cases runs first, followed by random requests under
// three idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_quaternion_compose_normalize_core;

   typedef struct {
      qcn_pkg::data_type w, x, y, z;
      logic              restart;
   } delta_req_type;

   typedef struct {
      qcn_pkg::data_type w, x, y, z;
      logic              degenerate;
   } attitude_type;

   typedef struct {
      delta_req_type d;
      bit            typed;
      attitude_type  want;
   } table_row_type;

   localparam qcn_pkg::data_type HALF        = qcn_pkg::ONE >>> 1;
   localparam qcn_pkg::data_type WORD_MIN    = 32'sh8000_0000;
   localparam qcn_pkg::data_type COS_45      = 32'sh2D41_3CCD;
   localparam int                HOLD_CYCLES = 600;
   localparam int                RANDOM_RUN  = 160;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   qcn_pkg::data_type req_delta_w = '0;
   qcn_pkg::data_type req_delta_x = '0;
   qcn_pkg::data_type req_delta_y = '0;
   qcn_pkg::data_type req_delta_z = '0;
   logic              req_restart = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   qcn_pkg::data_type rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z;
   logic              rsp_degenerate;

   longint        held_attitude[4] = '{longint'(qcn_pkg::ONE), 0, 0, 0};
   attitude_type  expected_attitudes[$];
   table_row_type directed_rows[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int errors = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int restarts_sent = 0;
   int degenerate_count = 0;
   int saturated_terms = 0;

   quaternion_compose_normalize_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_delta_w    (req_delta_w),
      .req_delta_x    (req_delta_x),
      .req_delta_y    (req_delta_y),
      .req_delta_z    (req_delta_z),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_w      (rsp_out_w),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_degenerate (rsp_degenerate)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("quaternion_compose_normalize_core test failed");
      $finish;
   end

   function automatic longint round_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< (qcn_pkg::FRAC_BITS - 1))) >>> qcn_pkg::FRAC_BITS;
   endfunction

   function automatic attitude_type compose_and_normalize(input delta_req_type d);
      longint a[4], b[4], t[4];
      longint unsigned mags[4], sum_sq, root, trial, q;
      attitude_type r;
      int i;
      b[0] = longint'(d.w);
      b[1] = longint'(d.x);
      b[2] = longint'(d.y);
      b[3] = longint'(d.z);
      if (d.restart) begin
         held_attitude = '{longint'(qcn_pkg::ONE), 0, 0, 0};
      end
      a = held_attitude;
      t[0] = round_mul(a[0], b[0]) - round_mul(a[1], b[1])
           - round_mul(a[2], b[2]) - round_mul(a[3], b[3]);
      t[1] = round_mul(a[1], b[0]) + round_mul(a[0], b[1])
           - round_mul(a[3], b[2]) + round_mul(a[2], b[3]);
      t[2] = round_mul(a[2], b[0]) + round_mul(a[3], b[1])
           + round_mul(a[0], b[2]) - round_mul(a[1], b[3]);
      t[3] = round_mul(a[3], b[0]) - round_mul(a[2], b[1])
           + round_mul(a[1], b[2]) + round_mul(a[0], b[3]);
      sum_sq = 0;
      for (i = 0; i < 4; i++) begin
         if (t[i] > longint'(qcn_pkg::SAT_MAX)) begin
            t[i] = longint'(qcn_pkg::SAT_MAX);
            saturated_terms++;
         end else if (t[i] < -longint'(qcn_pkg::SAT_MAX)) begin
            t[i] = -longint'(qcn_pkg::SAT_MAX);
            saturated_terms++;
         end
         mags[i] = (t[i] < 0) ? longint'(-t[i]) : t[i];
         sum_sq += mags[i] * mags[i];
      end
      root = 0;
      for (i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= sum_sq) begin
            root = trial;
         end
      end
      if (root == 0) begin
         degenerate_count++;
      end else begin
         for (i = 0; i < 4; i++) begin
            q = (mags[i] << qcn_pkg::FRAC_BITS) / root;
            if (q > longint'(qcn_pkg::SAT_MAX)) begin
               q = longint'(qcn_pkg::SAT_MAX);
            end
            held_attitude[i] = (t[i] < 0) ? -longint'(q) : longint'(q);
         end
      end
      r.w = qcn_pkg::data_type'(held_attitude[0]);
      r.x = qcn_pkg::data_type'(held_attitude[1]);
      r.y = qcn_pkg::data_type'(held_attitude[2]);
      r.z = qcn_pkg::data_type'(held_attitude[3]);
      r.degenerate = (root == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_component(input string name, input qcn_pkg::data_type got,
                                    input qcn_pkg::data_type want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s = %0d, expected %0d",
                                   responses_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin : response_check
      attitude_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_attitudes.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = expected_attitudes.pop_front();
            compare_component("w", rsp_out_w, want.w);
            compare_component("x", rsp_out_x, want.x);
            compare_component("y", rsp_out_y, want.y);
            compare_component("z", rsp_out_z, want.z);
            if (rsp_degenerate !== want.degenerate) begin
               report_mismatch($sformatf("response %0d degenerate = %b, expected %b",
                                         responses_checked, rsp_degenerate,
                                         want.degenerate));
            end
         end
         responses_checked++;
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_request(input delta_req_type d, input bit typed,
                               input attitude_type want);
      attitude_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_delta_w <= d.w;
      req_delta_x <= d.x;
      req_delta_y <= d.y;
      req_delta_z <= d.z;
      req_restart <= d.restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = compose_and_normalize(d);
      if (typed) begin
         expected_attitudes.push_back(want);
      end else begin
         expected_attitudes.push_back(predicted);
      end
      requests_sent++;
      if (d.restart) begin
         restarts_sent++;
      end
      @(negedge clock);
   endtask

   task automatic add_row(input qcn_pkg::data_type w, input qcn_pkg::data_type x,
                          input qcn_pkg::data_type y, input qcn_pkg::data_type z,
                          input logic restart, input bit typed,
                          input qcn_pkg::data_type ew, input qcn_pkg::data_type ex,
                          input qcn_pkg::data_type ey, input qcn_pkg::data_type ez,
                          input logic edeg);
      table_row_type row;
      row.d     = '{w, x, y, z, restart};
      row.typed = typed;
      row.want  = '{ew, ex, ey, ez, edeg};
      directed_rows.push_back(row);
   endtask

   function automatic qcn_pkg::data_type corner_value();
      case ($urandom_range(7))
         0:       return WORD_MIN;
         1:       return qcn_pkg::SAT_MAX;
         2:       return '0;
         3:       return 32'sd1;
         4:       return -32'sd1;
         5:       return qcn_pkg::ONE;
         6:       return -qcn_pkg::ONE;
         default: return qcn_pkg::data_type'($urandom());
      endcase
   endfunction

   task automatic run_random(input int count);
      delta_req_type d;
      attitude_type  unused;
      int pick;
      unused = '{'0, '0, '0, '0, 1'b0};
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // A small rotation keeps the orientation well away from the corners.
            d.w = qcn_pkg::ONE - qcn_pkg::data_type'($urandom_range(32'h000F_FFFF));
            d.x = qcn_pkg::data_type'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            d.y = qcn_pkg::data_type'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            d.z = qcn_pkg::data_type'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         end else if (pick < 70) begin
            d.w = qcn_pkg::data_type'($urandom());
            d.x = qcn_pkg::data_type'($urandom());
            d.y = qcn_pkg::data_type'($urandom());
            d.z = qcn_pkg::data_type'($urandom());
         end else if (pick < 75) begin
            d.w = '0;
            d.x = '0;
            d.y = '0;
            d.z = '0;
         end else if (pick < 82) begin
            d.w = qcn_pkg::data_type'($urandom_range(6)) - 32'sd3;
            d.x = qcn_pkg::data_type'($urandom_range(6)) - 32'sd3;
            d.y = qcn_pkg::data_type'($urandom_range(6)) - 32'sd3;
            d.z = qcn_pkg::data_type'($urandom_range(6)) - 32'sd3;
         end else begin
            d.w = corner_value();
            d.x = corner_value();
            d.y = corner_value();
            d.z = corner_value();
         end
         d.restart = ($urandom_range(99) < 12);
         send_request(d, 1'b0, unused);
      end
   endtask

   initial begin
      add_row(qcn_pkg::ONE, 0, 0, 0, 1'b0, 1'b1, qcn_pkg::ONE, 0, 0, 0, 1'b0);
      add_row(0, 0, 0, 0, 1'b0, 1'b1, qcn_pkg::ONE, 0, 0, 0, 1'b1);
      add_row(0, 0, 0, 0, 1'b1, 1'b1, qcn_pkg::ONE, 0, 0, 0, 1'b1);
      add_row(WORD_MIN, 0, 0, 0, 1'b1, 1'b1, -qcn_pkg::ONE, 0, 0, 0, 1'b0);
      add_row(qcn_pkg::SAT_MAX, qcn_pkg::SAT_MAX, qcn_pkg::SAT_MAX, qcn_pkg::SAT_MAX,
              1'b1, 1'b1, HALF, HALF, HALF, HALF, 1'b0);
      // Every partial product is an exact tie at minus one half and rounds up to zero.
      add_row(-1, -1, -1, -1, 1'b0, 1'b1, HALF, HALF, HALF, HALF, 1'b1);
      add_row(1, 1, 1, 1, 1'b0, 1'b1, -HALF, HALF, HALF, HALF, 1'b0);
      add_row(0, 0, 0, 0, 1'b1, 1'b1, qcn_pkg::ONE, 0, 0, 0, 1'b1);
      add_row(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1, 1'b1,
              -HALF, -HALF, -HALF, -HALF, 1'b0);
      add_row(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0);
      add_row(1, 0, 0, 0, 1'b1, 1'b1, qcn_pkg::ONE, 0, 0, 0, 1'b0);
      add_row(-1, 0, 0, 0, 1'b1, 1'b1, -qcn_pkg::ONE, 0, 0, 0, 1'b0);
      add_row(0, 1, 0, 0, 1'b1, 1'b1, 0, qcn_pkg::ONE, 0, 0, 1'b0);
      add_row(0, 0, -1, 0, 1'b1, 1'b1, 0, 0, -qcn_pkg::ONE, 0, 1'b0);
      add_row(0, 0, 0, qcn_pkg::SAT_MAX, 1'b1, 1'b1, 0, 0, 0, qcn_pkg::ONE, 1'b0);
      add_row(COS_45, 0, 0, COS_45, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0);
      add_row(COS_45, 0, 0, COS_45, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0);
      add_row(COS_45, COS_45, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0);
      add_row(0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0);
      add_row(qcn_pkg::ONE, qcn_pkg::ONE, qcn_pkg::ONE, qcn_pkg::ONE, 1'b0, 1'b0,
              0, 0, 0, 0, 1'b0);
      add_row(qcn_pkg::SAT_MAX, WORD_MIN, qcn_pkg::SAT_MAX, WORD_MIN, 1'b0, 1'b0,
              0, 0, 0, 0, 1'b0);
      add_row(WORD_MIN, qcn_pkg::SAT_MAX, WORD_MIN, qcn_pkg::SAT_MAX, 1'b1, 1'b0,
              0, 0, 0, 0, 1'b0);
      add_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 1'b0, 1'b0,
              0, 0, 0, 0, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 26;
      rsp_idle_pct <= 88;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].d, directed_rows[i].typed, directed_rows[i].want);
      end
      run_random(RANDOM_RUN);

      req_idle_pct = 88;
      rsp_idle_pct <= 26;
      run_random(RANDOM_RUN);

      // The receiver stalls for a long stretch while requests keep coming.
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      run_random(RANDOM_RUN);
      req_valid <= 1'b0;

      while (expected_attitudes.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Sent %0d requests: %0d with restart, %0d degenerate products, %0d saturated terms.",
               requests_sent, restarts_sent, degenerate_count, saturated_terms);
      $display("Checked %0d responses under three idling patterns and a %0d-cycle hold-off.",
               responses_checked, HOLD_CYCLES);
      if (errors == 0) begin
         $display("quaternion_compose_normalize_core test passed");
      end else begin
         $display("quaternion_compose_normalize_core test failed");
      end
      $finish;
   end

endmodule

[files.f]
design/qcn_pkg.sv
design/quaternion_compose_normalize_core.sv
design/qcn_checker.sv
verif/tb_quaternion_compose_normalize_core.sv
